// ===== rtl/pidhd_pkg.sv =====
// shared constants, register indexes and types for the pid heater duty controller
package pidhd_pkg;

  localparam int TEMP_WIDTH_DEF = 16;
  localparam int SUM_WIDTH_DEF  = 32;
  localparam int DUTY_MAX_DEF   = 1000;

  localparam int GAIN_W      = 16;
  localparam int OFFSET_W    = 11;
  localparam int DUTY_W      = 10;
  localparam int GAIN_SHIFT  = 12;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 16;

  localparam logic [GAIN_W-1:0]          GAIN_PROP_RST     = 16'd10240;
  localparam logic [GAIN_W-1:0]          GAIN_INTEG_RST    = 16'd410;
  localparam logic [GAIN_W-1:0]          GAIN_DERIV_RST    = 16'd16000;
  localparam logic signed [OFFSET_W-1:0] TARGET_OFFSET_RST = 11'sd80;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_GAIN_PROP     = 8'd0,
    REG_GAIN_INTEG    = 8'd1,
    REG_GAIN_DERIV    = 8'd2,
    REG_TARGET_OFFSET = 8'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty;
    logic              high;
  } duty_res_t;

endpackage

// ===== rtl/pidhd_clamp.sv =====
// scales the summed pid terms down and clamps them to the duty range
module pidhd_clamp #(
  parameter int ACC_W    = 51,
  parameter int DUTY_MAX = 1000
) (
  input  logic signed [ACC_W-1:0] total,
  output pidhd_pkg::duty_res_t    res
);
  import pidhd_pkg::*;

  localparam logic signed [ACC_W-1:0] DMAX     = ACC_W'(DUTY_MAX);
  localparam logic [DUTY_W-1:0]       DMAX_OUT = DUTY_W'(DUTY_MAX);

  logic signed [ACC_W-1:0] shifted;

  // arithmetic shift rounds toward minus infinity
  assign shifted = total >>> GAIN_SHIFT;

  always_comb begin
    res.high = 1'b0;
    res.duty = DUTY_W'(1);
    if (!total[ACC_W-1]) begin
      if (shifted > DMAX) begin
        res.duty = DMAX_OUT;
        res.high = 1'b1;
      end else if (shifted != '0) begin
        res.duty = shifted[DUTY_W-1:0];
      end
    end
  end

endmodule

// ===== rtl/pid_heater_duty_controller_core.sv =====
// top level of the pid heater duty controller: registers, error state and pipeline
//
// Usage:
//   s_axis carries one temperature sample per item: setpoint and measured value,
//   signed, in 1/16 degree units. m_axis returns one duty item per sample: the
//   PWM compare value (1..DUTY_MAX) and a flag set when the output was clamped high.
//   cfg writes gains (unsigned Q4.12) and the target offset by register index;
//   cfg_ready is always high, writes to unknown indexes are dropped. Write
//   configuration only while no sample is in flight.
//   Error and saturating sum are registered at accept into stage 1, the three
//   gain multiplies into stage 2, and the add, shift and clamp into the output
//   register. Throughput is one item per cycle while m_axis does not stall;
//   the error state is updated in the first stage, so consecutive samples
//   chain without a gap.
//   Each stage holds when the next one is full and stalled, so a stall on m_axis
//   backs up stage by stage; s_axis_tready drops only when all stages are full.
//   Reset restores the default gains and offset, clears the error sum and the
//   previous error, and empties the pipeline.
module pid_heater_duty_controller_core #(
  parameter int TEMP_WIDTH = pidhd_pkg::TEMP_WIDTH_DEF,
  parameter int SUM_WIDTH  = pidhd_pkg::SUM_WIDTH_DEF,
  parameter int DUTY_MAX   = pidhd_pkg::DUTY_MAX_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // setpoint_temp, measured_temp
  input  logic [((2*TEMP_WIDTH+7)/8)*8-1:0]  s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // duty_value, saturated_high
  output logic [pidhd_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pidhd_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [pidhd_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pidhd_pkg::*;

  localparam int EW    = TEMP_WIDTH + 2;
  localparam int DW    = EW + 1;
  localparam int ACC_W = ((SUM_WIDTH > DW) ? SUM_WIDTH : DW) + GAIN_W + 3;
  localparam logic signed [SUM_WIDTH-1:0] SUM_MAX = {1'b0, {(SUM_WIDTH-1){1'b1}}};
  localparam logic signed [SUM_WIDTH-1:0] SUM_MIN = {1'b1, {(SUM_WIDTH-1){1'b0}}};

  // configuration
  logic [GAIN_W-1:0]          gain_prop;
  logic [GAIN_W-1:0]          gain_integ;
  logic [GAIN_W-1:0]          gain_deriv;
  logic signed [OFFSET_W-1:0] target_offset;

  // controller state
  logic signed [EW-1:0]        previous_error;
  logic signed [SUM_WIDTH-1:0] error_sum;

  // stage 1
  logic                        v1;
  logic signed [EW-1:0]        s1_err;
  logic signed [SUM_WIDTH-1:0] s1_sum;
  logic signed [DW-1:0]        s1_diff;

  // stage 2
  logic                             v2;
  logic signed [EW+GAIN_W:0]        p_prop;
  logic signed [SUM_WIDTH+GAIN_W:0] p_integ;
  logic signed [DW+GAIN_W:0]        p_deriv;

  // output stage
  logic      vo;
  duty_res_t out_res;

  logic                        in_accept;
  logic                        out_ready;
  logic                        r2;
  logic signed [TEMP_WIDTH-1:0] setpoint;
  logic signed [TEMP_WIDTH-1:0] measured;
  logic signed [EW-1:0]        err_next;
  logic signed [SUM_WIDTH:0]   sum_wide;
  logic signed [SUM_WIDTH-1:0] sum_next;
  logic signed [ACC_W-1:0]     total;
  duty_res_t                   res_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_prop     <= GAIN_PROP_RST;
      gain_integ    <= GAIN_INTEG_RST;
      gain_deriv    <= GAIN_DERIV_RST;
      target_offset <= TARGET_OFFSET_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GAIN_PROP:     gain_prop     <= cfg_data;
        REG_GAIN_INTEG:    gain_integ    <= cfg_data;
        REG_GAIN_DERIV:    gain_deriv    <= cfg_data;
        REG_TARGET_OFFSET: target_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  // stall propagates back one stage at a time
  assign out_ready     = !vo || m_axis_tready;
  assign r2            = !v2 || out_ready;
  assign s_axis_tready = !v1 || r2;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  assign setpoint = s_axis_tdata[TEMP_WIDTH-1:0];
  assign measured = s_axis_tdata[2*TEMP_WIDTH-1:TEMP_WIDTH];

  always_comb begin
    err_next = EW'(setpoint) + EW'(target_offset) - EW'(measured);
    sum_wide = (SUM_WIDTH+1)'(error_sum) + (SUM_WIDTH+1)'(err_next);
    // top two bits disagree on overflow past either limit
    case (sum_wide[SUM_WIDTH:SUM_WIDTH-1])
      2'b01:   sum_next = SUM_MAX;
      2'b10:   sum_next = SUM_MIN;
      default: sum_next = sum_wide[SUM_WIDTH-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= '0;
      error_sum      <= '0;
      v1             <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        v1 <= in_accept;
      end
      if (in_accept) begin
        previous_error <= err_next;
        error_sum      <= sum_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_err  <= err_next;
      s1_sum  <= sum_next;
      s1_diff <= DW'(err_next) - DW'(previous_error);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (r2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) begin
      p_prop  <= $signed({1'b0, gain_prop}) * s1_err;
      p_integ <= $signed({1'b0, gain_integ}) * s1_sum;
      p_deriv <= $signed({1'b0, gain_deriv}) * s1_diff;
    end
  end

  assign total = ACC_W'(p_prop) + ACC_W'(p_integ) + ACC_W'(p_deriv);

  pidhd_clamp #(
    .ACC_W    (ACC_W),
    .DUTY_MAX (DUTY_MAX)
  ) u_clamp (
    .total (total),
    .res   (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (out_ready) begin
      vo <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && v2) begin
      out_res <= res_next;
    end
  end

  assign m_axis_tvalid = vo;
  assign m_axis_tdata  = {{(OUT_TDATA_W-DUTY_W-1){1'b0}}, out_res.high, out_res.duty};

endmodule
